// ===== src/record_batch_stream_parser_core_defines.svh =====
// Assertion macros shared by the checker of the record batch stream parser.
`ifndef RECORD_BATCH_STREAM_PARSER_CORE_DEFINES_SVH
`define RECORD_BATCH_STREAM_PARSER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define RBSP_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a same-cycle implication outside reset.
`define RBSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication outside reset.
`define RBSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rbsp_pkg.sv =====
// Types and constants shared by the record batch stream parser modules.
package rbsp_pkg;

    // Result queue depth
    localparam int RES_FIFO_DEPTH = 4;

    // Register map (index taken from paddr[2])
    localparam int  APB_ADDR_W   = 3;
    localparam logic REG_PUT_TYPE = 1'b0;
    localparam logic [7:0] PUT_TYPE_RESET = 8'd1;

    // Event codes
    localparam logic [2:0] EV_SEQ  = 3'd0;
    localparam logic [2:0] EV_CNT  = 3'd1;
    localparam logic [2:0] EV_REC  = 3'd2;
    localparam logic [2:0] EV_KEY  = 3'd3;
    localparam logic [2:0] EV_VLEN = 3'd4;
    localparam logic [2:0] EV_VAL  = 3'd5;
    localparam logic [2:0] EV_END  = 3'd6;

    // Status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_LENGTH    = 4'd2;
    localparam logic [3:0] ST_CHECKSUM  = 4'd3;
    localparam logic [3:0] ST_TR_RECORD = 4'd4;
    localparam logic [3:0] ST_TR_KLEN   = 4'd5;
    localparam logic [3:0] ST_TR_KEY    = 4'd6;
    localparam logic [3:0] ST_TR_VLEN   = 4'd7;
    localparam logic [3:0] ST_TR_VALUE  = 4'd8;

    // Result tdata layout
    localparam int TDATA_W       = 80;
    localparam int TD_ISPUT_BIT  = 72;
    localparam int TD_STATUS_LSB = 73;
    localparam int TD_STATUS_MSB = 76;

    // Parse phase, one-hot
    typedef enum logic [8:0] {
        PH_HDR  = 9'b000000001,
        PH_SEQ  = 9'b000000010,
        PH_CNT  = 9'b000000100,
        PH_TYPE = 9'b000001000,
        PH_KLEN = 9'b000010000,
        PH_KEY  = 9'b000100000,
        PH_VLEN = 9'b001000000,
        PH_VAL  = 9'b010000000,
        PH_DONE = 9'b100000000
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [63:0] word;
        logic        is_put;
        logic [3:0]  status;
        logic        final_res;
    } result_t;

    // Results produced by one accepted byte, slot0 first
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } push_t;

endpackage

// ===== src/record_batch_stream_parser_core.sv =====
// Top level of the record batch stream parser: stream ports, register port, queue.
//
//  Channel | Dir | Transaction                    | tdata / tuser / tlast
//  s_axis  | in  | one batch byte                 | byte_value / - / is_last
//  m_axis  | out | one parse or end event         | data,word,is_put,status / event / final
//  apb     | in  | put_type_code write and read   | pwdata[7:0] at address 0
//
//  One byte per cycle is parsed in a single registered step; the byte's results go
//  straight into a 4-entry result queue, so s_axis_tready stays high while two queue
//  slots are free. A byte with both a parse event and the end event yields two output
//  transactions, the parse event first. Reset (synchronous aresetn) clears parse state and the queue and sets
//  put_type_code to 1. A stalled m_axis holds its transaction; input stalls once
//  three or more results wait in the queue.
module record_batch_stream_parser_core
    import rbsp_pkg::*;
#(
    parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_axis_tdata: byte_value[7:0]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tlast,
    // m_axis_tdata: data_byte[7:0], word[71:8], is_put[72], status[76:73], zero[79:77]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,
    // m_axis_tuser: event_res[2:0]
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       put_code_wr;
    logic [7:0] put_type_reg;
    logic       accept;
    push_t      push;
    logic       room;
    result_t    head;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PUT_TYPE) ? {24'd0, put_type_reg} : 32'd0;
    assign put_code_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PUT_TYPE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            put_type_reg <= PUT_TYPE_RESET;
        end else if (put_code_wr) begin
            put_type_reg <= pwdata[7:0];
        end
    end

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rbsp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .byte_value (s_axis_tdata),
        .is_last    (s_axis_tlast),
        .put_code   (put_type_reg),
        .push       (push)
    );

    rbsp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    // Pack the head result onto the stream
    assign m_axis_tdata = {3'b000, head.status, head.is_put, head.word, head.data_byte};
    assign m_axis_tuser = head.event_res;
    assign m_axis_tlast = head.final_res;

endmodule

// ===== src/rbsp_parser.sv =====
// Per-byte parse step: batch state registers and the results of each accepted byte.
module rbsp_parser
    import rbsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] byte_value,
    input  logic       is_last,
    input  logic [7:0] put_code,
    output push_t      push
);

    logic [32:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] csum_reg, csum_next;
    logic [31:0] trail_reg, trail_next;
    logic [63:0] word_reg, word_next;
    logic [31:0] rec_left_reg, rec_left_next;
    logic [31:0] field_left_reg, field_left_next;
    phase_t      phase_reg, phase_next;
    logic        is_put_reg, is_put_next;
    logic [3:0]  trunc_reg, trunc_next;

    // Map the phase reached at the end of the body to a truncation code
    function automatic logic [3:0] trunc_code(input phase_t ph);
        logic [3:0] code;
        case (ph)
            PH_SEQ, PH_CNT, PH_TYPE: code = ST_TR_RECORD;
            PH_KLEN:                 code = ST_TR_KLEN;
            PH_KEY:                  code = ST_TR_KEY;
            PH_VLEN:                 code = ST_TR_VLEN;
            PH_VAL:                  code = ST_TR_VALUE;
            default:                 code = ST_OK;
        endcase
        return code;
    endfunction

    always_comb begin
        logic [33:0] pos34;
        logic [33:0] len34;
        logic        in_hdr;
        logic        in_body;
        logic        in_trail;
        logic [63:0] shifted;
        logic [31:0] hi;
        logic [31:0] field_dec;
        logic        field_done;
        logic [31:0] rec_dec;
        logic [1:0]  trail_idx;
        logic        ev_valid;
        result_t     ev;
        result_t     fin;
        logic [3:0]  st;

        pos34      = {1'b0, pos_reg};
        len34      = {2'b00, len_reg};
        in_hdr     = (pos_reg < 33'd4);
        in_body    = !in_hdr && (pos34 < len34);
        in_trail   = !in_hdr && !in_body && (pos34 < (len34 + 34'd4));
        shifted    = {byte_value, word_reg[63:8]};
        hi         = shifted[63:32];
        field_dec  = field_left_reg - 32'd1;
        field_done = (field_left_reg == 32'd1);
        rec_dec    = (rec_left_reg != 32'd0) ? (rec_left_reg - 32'd1) : 32'd0;
        trail_idx  = pos_reg[1:0] - len_reg[1:0];

        pos_next        = pos_reg;
        len_next        = len_reg;
        csum_next       = csum_reg;
        trail_next      = trail_reg;
        word_next       = word_reg;
        rec_left_next   = rec_left_reg;
        field_left_next = field_left_reg;
        phase_next      = phase_reg;
        is_put_next     = is_put_reg;
        trunc_next      = trunc_reg;

        ev_valid = 1'b0;
        ev       = '0;
        fin      = '0;
        st       = ST_OK;

        if (in_hdr) begin
            // Assemble the declared length, little endian
            len_next = len_reg | ({24'd0, byte_value} << {pos_reg[1:0], 3'b000});
            if (pos_reg[1:0] == 2'd3) begin
                phase_next      = PH_SEQ;
                field_left_next = 32'd8;
                word_next       = '0;
            end
        end else if (in_body) begin
            // Accumulate the body checksum: sum*31 + byte
            csum_next = (csum_reg << 5) - csum_reg + {24'd0, byte_value};
            case (phase_reg)
                PH_SEQ: begin
                    word_next       = shifted;
                    field_left_next = field_dec;
                    if (field_done) begin
                        ev_valid        = 1'b1;
                        ev.event_res    = EV_SEQ;
                        ev.word         = shifted;
                        phase_next      = PH_CNT;
                        field_left_next = 32'd4;
                        word_next       = '0;
                    end
                end
                PH_CNT: begin
                    word_next       = shifted;
                    field_left_next = field_dec;
                    if (field_done) begin
                        ev_valid      = 1'b1;
                        ev.event_res  = EV_CNT;
                        ev.word       = {32'd0, hi};
                        rec_left_next = hi;
                        phase_next    = (hi != 32'd0) ? PH_TYPE : PH_DONE;
                    end
                end
                PH_TYPE: begin
                    is_put_next     = (byte_value == put_code);
                    phase_next      = PH_KLEN;
                    field_left_next = 32'd4;
                    word_next       = '0;
                end
                PH_KLEN: begin
                    word_next       = shifted;
                    field_left_next = field_dec;
                    if (field_done) begin
                        ev_valid     = 1'b1;
                        ev.event_res = EV_REC;
                        ev.word      = {32'd0, hi};
                        ev.is_put    = is_put_reg;
                        word_next    = '0;
                        if (hi != 32'd0) begin
                            phase_next      = PH_KEY;
                            field_left_next = hi;
                        end else begin
                            phase_next      = PH_VLEN;
                            field_left_next = 32'd4;
                        end
                    end
                end
                PH_KEY: begin
                    ev_valid        = 1'b1;
                    ev.event_res    = EV_KEY;
                    ev.data_byte    = byte_value;
                    field_left_next = field_dec;
                    if (field_done) begin
                        phase_next      = PH_VLEN;
                        field_left_next = 32'd4;
                        word_next       = '0;
                    end
                end
                PH_VLEN: begin
                    word_next       = shifted;
                    field_left_next = field_dec;
                    if (field_done) begin
                        ev_valid     = 1'b1;
                        ev.event_res = EV_VLEN;
                        ev.word      = {32'd0, hi};
                        if (hi != 32'd0) begin
                            phase_next      = PH_VAL;
                            field_left_next = hi;
                            word_next       = '0;
                        end else begin
                            rec_left_next = rec_dec;
                            phase_next    = (rec_dec != 32'd0) ? PH_TYPE : PH_DONE;
                        end
                    end
                end
                PH_VAL: begin
                    // Delete records consume value bytes silently
                    if (is_put_reg) begin
                        ev_valid     = 1'b1;
                        ev.event_res = EV_VAL;
                        ev.data_byte = byte_value;
                    end
                    field_left_next = field_dec;
                    if (field_done) begin
                        rec_left_next = rec_dec;
                        phase_next    = (rec_dec != 32'd0) ? PH_TYPE : PH_DONE;
                    end
                end
                default: begin
                end
            endcase
            // Latch the truncation code on the last body byte
            if (pos34 == (len34 - 34'd1)) begin
                trunc_next = trunc_code(phase_next);
            end
        end else if (in_trail) begin
            trail_next = trail_reg | ({24'd0, byte_value} << {trail_idx, 3'b000});
        end

        // Saturating byte position
        if (pos_reg != '1) begin
            pos_next = pos_reg + 33'd1;
        end

        // Final status in priority order
        if (pos_reg < 33'd11 || len_next < 32'd16) begin
            st = ST_SHORT;
        end else if (pos34 != ({2'b00, len_next} + 34'd3)) begin
            st = ST_LENGTH;
        end else if (csum_next != trail_next) begin
            st = ST_CHECKSUM;
        end else begin
            st = trunc_next;
        end
        fin.event_res = EV_END;
        fin.status    = st;
        fin.final_res = 1'b1;

        // Pack results, parse event ahead of the end event
        push.count = '0;
        push.slot0 = ev;
        push.slot1 = fin;
        if (accept) begin
            if (ev_valid && is_last) begin
                push.count = 2'd2;
            end else if (ev_valid) begin
                push.count = 2'd1;
            end else if (is_last) begin
                push.count = 2'd1;
                push.slot0 = fin;
            end
        end
    end

    // Update state on each accepted byte; the final byte clears the batch
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && is_last)) begin
            pos_reg        <= '0;
            len_reg        <= '0;
            csum_reg       <= '0;
            trail_reg      <= '0;
            word_reg       <= '0;
            rec_left_reg   <= '0;
            field_left_reg <= '0;
            phase_reg      <= PH_HDR;
            is_put_reg     <= 1'b0;
            trunc_reg      <= ST_OK;
        end else if (accept) begin
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            csum_reg       <= csum_next;
            trail_reg      <= trail_next;
            word_reg       <= word_next;
            rec_left_reg   <= rec_left_next;
            field_left_reg <= field_left_next;
            phase_reg      <= phase_next;
            is_put_reg     <= is_put_next;
            trunc_reg      <= trunc_next;
        end
    end

endmodule

// ===== src/rbsp_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
module rbsp_result_fifo
    import rbsp_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entries_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   tail_inc, tail_inc2;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[head_reg];
    // Accept a byte only while two slots are free
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign tail_inc  = wrap_inc(tail_reg);
    assign tail_inc2 = wrap_inc(tail_inc);

    always_comb begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = tail_inc;
            2'd2:    tail_next = tail_inc2;
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[tail_reg] <= push.slot0;
        end
        if (push.count == 2'd2) begin
            entries_reg[tail_inc] <= push.slot1;
        end
    end

endmodule

// ===== src/rbsp_checker.sv =====
// Port-level checker for the record batch stream parser, bound to the top level.
`include "record_batch_stream_parser_core_defines.svh"

module rbsp_checker
    import rbsp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // End event and tlast travel together
    `RBSP_ASSERT_IMPL(a_end_is_last, m_axis_tvalid && (m_axis_tuser == EV_END), m_axis_tlast, "end event without tlast")
    `RBSP_ASSERT_IMPL(a_last_is_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser == EV_END, "tlast on a parse event")
    // Status only on the end event, put flag only on record start
    `RBSP_ASSERT_IMPL(a_status_end, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[TD_STATUS_MSB:TD_STATUS_LSB] == ST_OK, "status on a parse event")
    `RBSP_ASSERT_IMPL(a_put_rec, m_axis_tvalid && (m_axis_tuser != EV_REC), !m_axis_tdata[TD_ISPUT_BIT], "put flag outside record start")
    // Stalled transaction holds
    `RBSP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind record_batch_stream_parser_core rbsp_checker u_rbsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the record batch stream parser: directed table, then random batches.
module tb;
    import rbsp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BYTES = 125;

    // One directed step: the byte, its last flag and, where one is due, the event it causes
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        has_ev;
        logic [2:0]  ev;
        logic [63:0] word;
        logic [3:0]  st;
    } step_row_t;

    // Single-byte batch, minimal all-zero batch (no records, zero checksum), single zero byte
    localparam step_row_t DIRECTED_STEPS [22] = '{
        '{8'hFF, 1'b1, 1'b1, EV_END, 64'd0, ST_SHORT},
        '{8'h10, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b1, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b1, EV_CNT, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b0, 1'b0, EV_SEQ, 64'd0, ST_OK},
        '{8'h00, 1'b1, 1'b1, EV_END, 64'd0, ST_OK},
        '{8'h00, 1'b1, 1'b1, EV_END, 64'd0, ST_SHORT}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    record_batch_stream_parser_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Parser state mirrored by the testbench
    logic [7:0]  put_code;
    logic [32:0] byte_pos;
    logic [31:0] decl_len;
    logic [31:0] body_sum;
    logic [31:0] trailer_sum;
    logic [63:0] shift_word;
    logic [31:0] recs_left;
    logic [31:0] field_left;
    phase_t      phase;
    logic        rec_is_put;
    logic [3:0]  trunc_status;

    result_t     event_queue[$];
    logic [7:0]  batch_bytes[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          src_idle    = 0;
    int          sink_stall  = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void push_event(logic [2:0] ev, logic [7:0] data, logic [63:0] w,
                                       logic put, logic [3:0] st);
        result_t r;
        r.event_res = ev;
        r.data_byte = data;
        r.word      = w;
        r.is_put    = put;
        r.status    = st;
        r.final_res = (ev == EV_END);
        event_queue = {event_queue, r};
    endfunction

    function automatic void clear_parser();
        byte_pos     = '0;
        decl_len     = '0;
        body_sum     = '0;
        trailer_sum  = '0;
        shift_word   = '0;
        recs_left    = '0;
        field_left   = '0;
        phase        = PH_HDR;
        rec_is_put   = 1'b0;
        trunc_status = ST_OK;
    endfunction

    function automatic void begin_field(phase_t ph, logic [31:0] n);
        phase      = ph;
        field_left = n;
        shift_word = '0;
    endfunction

    // Shift a little-endian byte in from the top; true when the field is complete
    function automatic bit shift_byte(logic [7:0] b);
        shift_word = {b, shift_word[63:8]};
        field_left = field_left - 1;
        return field_left == 0;
    endfunction

    function automatic void close_record();
        if (recs_left != 0)
            recs_left = recs_left - 1;
        phase = (recs_left != 0) ? PH_TYPE : PH_DONE;
    endfunction

    function automatic void parse_body_byte(logic [7:0] b);
        logic [31:0] len;
        case (phase)
            PH_SEQ: begin
                if (shift_byte(b)) begin
                    push_event(EV_SEQ, 8'd0, shift_word, 1'b0, ST_OK);
                    begin_field(PH_CNT, 32'd4);
                end
            end
            PH_CNT: begin
                if (shift_byte(b)) begin
                    recs_left = shift_word[63:32];
                    push_event(EV_CNT, 8'd0, {32'd0, recs_left}, 1'b0, ST_OK);
                    phase = (recs_left != 0) ? PH_TYPE : PH_DONE;
                end
            end
            PH_TYPE: begin
                rec_is_put = (b == put_code);
                begin_field(PH_KLEN, 32'd4);
            end
            PH_KLEN: begin
                if (shift_byte(b)) begin
                    len = shift_word[63:32];
                    push_event(EV_REC, 8'd0, {32'd0, len}, rec_is_put, ST_OK);
                    if (len != 0)
                        begin_field(PH_KEY, len);
                    else
                        begin_field(PH_VLEN, 32'd4);
                end
            end
            PH_KEY: begin
                push_event(EV_KEY, b, 64'd0, 1'b0, ST_OK);
                field_left = field_left - 1;
                if (field_left == 0)
                    begin_field(PH_VLEN, 32'd4);
            end
            PH_VLEN: begin
                if (shift_byte(b)) begin
                    len = shift_word[63:32];
                    push_event(EV_VLEN, 8'd0, {32'd0, len}, 1'b0, ST_OK);
                    if (len != 0)
                        begin_field(PH_VAL, len);
                    else
                        close_record();
                end
            end
            PH_VAL: begin
                // Delete records consume their value bytes silently
                if (rec_is_put)
                    push_event(EV_VAL, b, 64'd0, 1'b0, ST_OK);
                field_left = field_left - 1;
                if (field_left == 0)
                    close_record();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [3:0] trunc_code();
        case (phase)
            PH_TYPE, PH_SEQ, PH_CNT: return ST_TR_RECORD;
            PH_KLEN:                 return ST_TR_KLEN;
            PH_KEY:                  return ST_TR_KEY;
            PH_VLEN:                 return ST_TR_VLEN;
            PH_VAL:                  return ST_TR_VALUE;
            default:                 return ST_OK;
        endcase
    endfunction

    // Advance the mirrored parser by one accepted byte and queue the events it causes
    function automatic void parse_byte(logic [7:0] b, logic last);
        logic [32:0] p;
        logic [32:0] l;
        logic [32:0] d;
        logic [33:0] size;
        logic [3:0]  st;
        p = byte_pos;
        l = {1'b0, decl_len};
        if (p < 4) begin
            decl_len[8*p[1:0] +: 8] = b;
            if (p == 3)
                begin_field(PH_SEQ, 32'd8);
        end else if (p < l) begin
            body_sum = body_sum * 31 + b;
            parse_body_byte(b);
            if (p == l - 1)
                trunc_status = trunc_code();
        end else if (p < l + 4) begin
            d = p - l;
            trailer_sum[8*d[1:0] +: 8] = b;
        end
        if (byte_pos != '1)
            byte_pos = byte_pos + 1;
        if (last) begin
            size = {1'b0, p} + 34'd1;
            if (size < 12 || decl_len < 16)
                st = ST_SHORT;
            else if (size != {2'b00, decl_len} + 34'd4)
                st = ST_LENGTH;
            else if (body_sum != trailer_sum)
                st = ST_CHECKSUM;
            else
                st = trunc_status;
            push_event(EV_END, 8'd0, 64'd0, 1'b0, st);
            clear_parser();
        end
    endfunction

    function automatic void add_le32(ref logic [7:0] q[$], input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            q = {q, v[8*k +: 8]};
    endfunction

    // Build one batch: mostly well formed, some with a bad checksum, cut body,
    // overstated count, oversized field, wrong size, or plain noise
    function automatic void build_batch();
        logic [7:0]  body[$];
        logic [31:0] cnt_field;
        logic [31:0] klen;
        logic [31:0] vlen;
        logic [31:0] ck;
        int          kind;
        int          seq_mode;
        int          n_rec;
        int          nk;
        int          nv;
        int          n;
        bit          stop;
        batch_bytes = {};
        kind = $urandom_range(0, 19);
        if (kind >= 18) begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
                batch_bytes = {batch_bytes, 8'($urandom)};
            // Half the time declare a length below the minimum
            if (n >= 4 && $urandom_range(0, 1)) begin
                batch_bytes[0] = 8'($urandom_range(0, 15));
                batch_bytes[1] = 8'h00;
                batch_bytes[2] = 8'h00;
                batch_bytes[3] = 8'h00;
            end
            return;
        end
        seq_mode = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++)
            body = {body, (seq_mode == 0 ? 8'h00 : seq_mode == 1 ? 8'hFF : 8'($urandom))};
        n_rec = $urandom_range(0, 3);
        cnt_field = n_rec;
        if (kind == 15)
            cnt_field = n_rec + $urandom_range(1, 2);
        if (kind == 16)
            cnt_field = $urandom;
        add_le32(body, cnt_field);
        for (int i = 0; i < n_rec; i++) begin
            body = {body, ($urandom_range(0, 1) ? put_code : 8'($urandom))};
            klen = $urandom_range(0, 3);
            vlen = $urandom_range(0, 4);
            nk   = klen;
            nv   = vlen;
            stop = 1'b0;
            // Give the last record a length far beyond the body
            if (kind == 16 && i == n_rec - 1) begin
                if ($urandom_range(0, 1)) begin
                    klen = $urandom | 32'h100;
                    nk   = $urandom_range(0, 3);
                    stop = 1'b1;
                end else begin
                    vlen = $urandom | 32'h100;
                    nv   = $urandom_range(0, 3);
                end
            end
            add_le32(body, klen);
            for (int j = 0; j < nk; j++)
                body = {body, 8'($urandom)};
            if (stop)
                break;
            add_le32(body, vlen);
            for (int j = 0; j < nv; j++)
                body = {body, 8'($urandom)};
        end
        // Trailing slack after the last record
        if (kind < 10 && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                body = {body, 8'($urandom)};
        end
        // Cut the body short so that a record is left incomplete
        if (kind >= 12 && kind <= 14 && body.size() > 12) begin
            n = $urandom_range(12, body.size() - 1);
            body = body[0:n-1];
        end
        ck = '0;
        foreach (body[i])
            ck = ck * 31 + body[i];
        if (kind == 10 || kind == 11)
            ck = ck ^ (32'd1 << $urandom_range(0, 31));
        add_le32(batch_bytes, body.size() + 4);
        foreach (body[i])
            batch_bytes = {batch_bytes, body[i]};
        add_le32(batch_bytes, ck);
        // Stretch or shorten the stream against its declared length
        if (kind == 17) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                if (seq_mode[0])
                    batch_bytes = {batch_bytes, 8'($urandom)};
                else
                    void'(batch_bytes.pop_back());
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic write_put_code(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PUT_TYPE, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        put_code = value;
        // Read the register back
        @(posedge aclk);
        if (prdata !== {24'd0, value}) begin
            mismatches <= mismatches + 1;
            $display("%0t: put code readback expected %h actual %h",
                     $time, {24'd0, value}, prdata);
        end
    endtask

    // Wait for every queued event, then let the pipeline settle
    task automatic drain_events();
        while (event_queue.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Stall the result side and check each accepted transaction
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.event_res = m_axis_tuser;
            got.data_byte = m_axis_tdata[7:0];
            got.word      = m_axis_tdata[71:8];
            got.is_put    = m_axis_tdata[TD_ISPUT_BIT];
            got.status    = m_axis_tdata[TD_STATUS_MSB:TD_STATUS_LSB];
            got.final_res = m_axis_tlast;
            if (event_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                $display("%0t: unexpected event: ev=%0d data=%h word=%h put=%b st=%0d last=%b",
                         $time, got.event_res, got.data_byte, got.word, got.is_put,
                         got.status, got.final_res);
            end else begin
                want = event_queue.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: mismatch expected ev=%0d data=%h word=%h put=%b st=%0d last=%b",
                             $time, want.event_res, want.data_byte, want.word, want.is_put,
                             want.status, want.final_res);
                    $display("%0t:          actual   ev=%0d data=%h word=%h put=%b st=%0d last=%b",
                             $time, got.event_res, got.data_byte, got.word, got.is_put,
                             got.status, got.final_res);
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] cfg_values [4];
        int         qs;
        int         phase_bytes;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        put_code = PUT_TYPE_RESET;
        clear_parser();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: expected events typed in, mirror kept in step
        for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
            send_byte(DIRECTED_STEPS[i].b, DIRECTED_STEPS[i].last);
            qs = event_queue.size();
            parse_byte(DIRECTED_STEPS[i].b, DIRECTED_STEPS[i].last);
            while (event_queue.size() > qs)
                void'(event_queue.pop_back());
            if (DIRECTED_STEPS[i].has_ev)
                push_event(DIRECTED_STEPS[i].ev, 8'd0, DIRECTED_STEPS[i].word, 1'b0,
                           DIRECTED_STEPS[i].st);
        end
        s_axis_tvalid <= 1'b0;

        // Random batches over four idle profiles and four type codes
        cfg_values[0] = 8'h00;
        cfg_values[1] = 8'hFF;
        cfg_values[2] = 8'($urandom);
        cfg_values[3] = PUT_TYPE_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            drain_events();
            write_put_code(cfg_values[ph]);
            src_idle   = (ph == 1) ? 65 : (ph == 3) ? 29 : 0;
            sink_stall = (ph == 2) ? 65 : (ph == 3) ? 29 : 0;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_batch();
                for (int i = 0; i < batch_bytes.size(); i++) begin
                    send_byte(batch_bytes[i], i == batch_bytes.size() - 1);
                    parse_byte(batch_bytes[i], i == batch_bytes.size() - 1);
                    phase_bytes++;
                end
            end
            s_axis_tvalid <= 1'b0;
        end

        while (event_queue.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && event_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/rbsp_pkg.sv
src/rbsp_parser.sv
src/rbsp_result_fifo.sv
src/record_batch_stream_parser_core.sv
src/rbsp_checker.sv
verif/tb.sv
